// ----- rtl/tun_pkg.sv -----
// Package: shared widths, types and helpers for the triangle unit normal pipeline.
package tun_pkg;

	localparam int DefCoordWidth = 32;
	localparam int MagWidth      = 31;          // scaled magnitude width
	localparam int SumWidth      = 64;          // sum of three squares
	localparam int RootWidth     = 32;          // floor(sqrt(sum))
	localparam int NormWidth     = 32;          // Q2.30 output
	localparam int QuotWidth     = 31;          // quotient magnitude, at most 2^30
	localparam int NumWidth      = MagWidth + 30 + 1;

	// Square-root cell state: remainder, partial root
	typedef struct packed {
		logic [SumWidth-1:0]  rem;
		logic [RootWidth-1:0] root;
	} sqrt_cell_t;

	// Division cell state for the three components
	typedef struct packed {
		logic [NumWidth-1:0]  rem;
		logic [QuotWidth-1:0] quo;
	} div_cell_t;

	// Item side data carried alongside the cell chains
	typedef struct packed {
		logic [2:0]                neg;
		logic                      degen;
		logic [2:0][MagWidth-1:0]  mag;
	} side_t;

endpackage

// ----- rtl/tun_sqrt_cell.sv -----
// Square-root cell: one root bit per cell, restoring form.
module tun_sqrt_cell #(
	parameter int Step = 0
) (
	input  logic               clk,
	input  logic               en,
	input  tun_pkg::sqrt_cell_t din,
	output tun_pkg::sqrt_cell_t dout
);
	import tun_pkg::*;

	localparam int Sh = 2 * (RootWidth - 1 - Step);

	logic [SumWidth+1:0] trial;
	logic [SumWidth+1:0] remx;
	sqrt_cell_t          nxt;

	always_comb begin
		// trial = (4*root + 1) << Sh, compared against remainder
		trial = ({2'b00, {(SumWidth-RootWidth){1'b0}}, din.root} << (Sh + 2))
			| ((SumWidth+2)'(1) << Sh);
		remx = {2'b00, din.rem};
		nxt = din;
		if (remx >= trial) begin
			nxt.rem  = SumWidth'(remx - trial);
			nxt.root = {din.root[RootWidth-2:0], 1'b1};
		end else begin
			nxt.root = {din.root[RootWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ----- rtl/tun_div_cell.sv -----
// Division cell: one quotient bit per cell for one component.
module tun_div_cell (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tun_pkg::RootWidth-1:0]  divisor,
	input  logic                           num_bit,
	input  tun_pkg::div_cell_t             din,
	output tun_pkg::div_cell_t             dout
);
	import tun_pkg::*;

	logic [NumWidth:0] shifted;
	div_cell_t         nxt;

	always_comb begin
		shifted = {din.rem, num_bit};
		nxt.quo = {din.quo[QuotWidth-2:0], 1'b0};
		nxt.rem = din.rem;
		if (shifted >= {{(NumWidth+1-RootWidth){1'b0}}, divisor}) begin
			nxt.rem = NumWidth'(shifted - {{(NumWidth+1-RootWidth){1'b0}}, divisor});
			nxt.quo[0] = 1'b1;
		end else begin
			nxt.rem = NumWidth'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ----- rtl/triangle_unit_normal.sv -----
// Top level: triangle unit facet normal, pipelined chain of root and divide cells.
//
//  channel  | handshake      | payload
//  ---------+----------------+---------------------------------------------
//  input    | in_valid/stall | a_x..c_z, COORD_WIDTH bits, signed Q16.16
//  output   | out_valid/stall| normal_x/y/z (signed Q2.30), degenerate
//
// One item enters per cycle while in_stall is low; the pipeline holds the front
// end, one square-root cell per root bit and one divide cell per
// numerator bit of 2^30*m + R/2. The whole pipeline advances as one when
// the output stage is free, so out_stall holds every stage; in_stall is
// simply out_stall while the last stage is full. Reset clears only the
// valid bits; payload registers are left as they fall.
module triangle_unit_normal #(
	parameter int COORD_WIDTH = tun_pkg::DefCoordWidth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        a_x,
	input  logic signed [COORD_WIDTH-1:0]        a_y,
	input  logic signed [COORD_WIDTH-1:0]        a_z,
	input  logic signed [COORD_WIDTH-1:0]        b_x,
	input  logic signed [COORD_WIDTH-1:0]        b_y,
	input  logic signed [COORD_WIDTH-1:0]        b_z,
	input  logic signed [COORD_WIDTH-1:0]        c_x,
	input  logic signed [COORD_WIDTH-1:0]        c_y,
	input  logic signed [COORD_WIDTH-1:0]        c_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tun_pkg::NormWidth-1:0] normal_x,
	output logic signed [tun_pkg::NormWidth-1:0] normal_y,
	output logic signed [tun_pkg::NormWidth-1:0] normal_z,
	output logic                                 degenerate
);
	import tun_pkg::*;

	localparam int EW = COORD_WIDTH + 1;        // edge width
	localparam int PW = 2 * EW;                 // product width
	localparam int CW = PW + 1;                 // cross width
	localparam int LW = $clog2(CW + 1);
	localparam int NSQ = RootWidth;
	localparam int NDV = NumWidth;
	localparam int DEPTH = 4 + NSQ + NDV;

	// Whole chain moves together; a bubble anywhere still waits behind a stalled head.
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv      = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: edge vectors
	logic signed [EW-1:0] u_s1 [3];
	logic signed [EW-1:0] v_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1[0] <= EW'(b_x) - EW'(a_x);
			u_s1[1] <= EW'(b_y) - EW'(a_y);
			u_s1[2] <= EW'(b_z) - EW'(a_z);
			v_s1[0] <= EW'(c_x) - EW'(a_x);
			v_s1[1] <= EW'(c_y) - EW'(a_y);
			v_s1[2] <= EW'(c_z) - EW'(a_z);
		end
	end

	// Stage 2: six products; stage 3: cross components
	logic signed [PW-1:0] p_s2 [6];
	logic signed [CW-1:0] w_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= PW'(u_s1[1]) * PW'(v_s1[2]);
			p_s2[1] <= PW'(u_s1[2]) * PW'(v_s1[1]);
			p_s2[2] <= PW'(u_s1[2]) * PW'(v_s1[0]);
			p_s2[3] <= PW'(u_s1[0]) * PW'(v_s1[2]);
			p_s2[4] <= PW'(u_s1[0]) * PW'(v_s1[1]);
			p_s2[5] <= PW'(u_s1[1]) * PW'(v_s1[0]);
			w_s3[0] <= CW'(p_s2[0]) - CW'(p_s2[1]);
			w_s3[1] <= CW'(p_s2[2]) - CW'(p_s2[3]);
			w_s3[2] <= CW'(p_s2[4]) - CW'(p_s2[5]);
		end
	end

	// Stage 4: magnitudes, leading-one search, normalise to 31 bits
	logic [CW-1:0] wm [3];
	logic [CW-1:0] orv;
	logic [LW-1:0] blen;
	logic [2*CW-1:0] wide [3];
	side_t side_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wm[i] = w_s3[i][CW-1] ? CW'(-w_s3[i]) : CW'(w_s3[i]);
		end
		orv  = wm[0] | wm[1] | wm[2];
		blen = '0;
		for (int k = 0; k < CW; k++) begin
			if (orv[k]) begin
				blen = LW'(k + 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			// place the leading bit at position CW-1, then take the top 31 bits
			wide[i] = {wm[i], {CW{1'b0}}} >> blen;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				side_s4.neg[i] <= w_s3[i][CW-1];
				side_s4.mag[i] <= wide[i][CW-1 -: MagWidth];
			end
			side_s4.degen <= (orv == '0);
		end
	end

	// Square of magnitudes (3 multipliers) feeds the root chain
	sqrt_cell_t sq_in;
	always_comb begin
		sq_in.root = '0;
		sq_in.rem  = SumWidth'(side_s4.mag[0]) * SumWidth'(side_s4.mag[0])
			+ SumWidth'(side_s4.mag[1]) * SumWidth'(side_s4.mag[1])
			+ SumWidth'(side_s4.mag[2]) * SumWidth'(side_s4.mag[2]);
	end

	sqrt_cell_t sq_c [NSQ+1];
	side_t      sd_q [NSQ+NDV+1];
	assign sq_c[0] = sq_in;
	assign sd_q[0] = side_s4;

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		tun_sqrt_cell #(.Step(g)) u_cell (
			.clk (clk), .en (adv), .din (sq_c[g]), .dout (sq_c[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				sd_q[g+1] <= sd_q[g];
			end
		end
	end

	// Divide chain: numerator = m*2^30 + R/2, one bit per cell, MSB first
	logic [RootWidth-1:0] rt_q [NDV+1];
	div_cell_t dv_c [3][NDV+1];
	logic [NumWidth-1:0] numv [3];
	logic [NumWidth-1:0] nm_q [3][NDV+1];
	assign rt_q[0] = sq_c[NSQ].root;

	for (genvar j = 0; j < 3; j++) begin : g_comp
		assign numv[j] = {1'b0, sd_q[NSQ].mag[j], 30'b0}
			+ NumWidth'(sq_c[NSQ].root >> 1);
		assign dv_c[j][0] = '0;
		assign nm_q[j][0] = numv[j];
		for (genvar g = 0; g < NDV; g++) begin : g_div
			tun_div_cell u_cell (
				.clk (clk), .en (adv), .divisor (rt_q[g]),
				.num_bit (nm_q[j][g][NumWidth-1-g]),
				.din (dv_c[j][g]), .dout (dv_c[j][g+1])
			);
			always_ff @(posedge clk) begin
				if (adv) begin
					nm_q[j][g+1] <= nm_q[j][g];
				end
			end
		end
	end

	for (genvar g = 0; g < NDV; g++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_q[g+1]       <= rt_q[g];
				sd_q[NSQ+g+1]   <= sd_q[NSQ+g];
			end
		end
	end

	// Output: apply signs, zero on degenerate
	side_t sd_out;
	logic signed [NormWidth-1:0] nrm [3];
	assign sd_out = sd_q[NSQ+NDV];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = NormWidth'(dv_c[i][NDV].quo);
			if (sd_out.neg[i]) begin
				nrm[i] = -nrm[i];
			end
			if (sd_out.degen) begin
				nrm[i] = '0;
			end
		end
	end
	assign normal_x   = nrm[0];
	assign normal_y   = nrm[1];
	assign normal_z   = nrm[2];
	assign degenerate = sd_out.degen;

	// Checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(degenerate))
		else $error("result changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a full stalled output");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("degenerate item with non-zero normal");
endmodule
